@@ src/rvd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, operation codes and request type for the running variance block.
// No dependencies; used by rvd_unit and running_variance_decimated.
package rvd_pkg;

	localparam int MAX_SAMPLES = 16384;
	localparam int SAMPLE_BITS = 16;

	localparam int SAMPLE_W = 16;
	localparam int VAR_W    = 31;
	localparam int CNT_W    = 15;
	localparam int SUM_W    = 31;
	localparam int SSQ_W    = 45;
	localparam int SQ_W     = 31;
	localparam int MAG_W    = 30;
	localparam int DEN_W    = 29;
	localparam int RI_W     = 8;
	localparam int WIDE_W   = 60;
	localparam int LEN_W    = 5;
	localparam int OP_W     = 2;

	localparam logic [RI_W-1:0] RI_RESET = 8'd10;
	localparam logic [0:0] REG_REPORT_INTERVAL = 1'b0;

	localparam logic [OP_W-1:0] OP_MUL = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_DIV = 2'd2;

	localparam logic [LEN_W-1:0] LEN_CNT = 5'd15;
	localparam logic [LEN_W-1:0] LEN_MAG = 5'd30;
	localparam logic [LEN_W-1:0] LEN_SUB = 5'd1;
	localparam logic [LEN_W-1:0] LEN_DIV = 5'd31;

	typedef struct packed {
		logic             start;
		logic [OP_W-1:0]  op;
		logic [LEN_W-1:0] len;
	} unit_req_t;

endpackage

@@ src/rvd_unit.sv @@
`timescale 1ns / 1ps
// Shared iterative arithmetic unit: shift-add multiply, subtract, restoring divide.
// One 61-bit adder/subtractor serves every operation. Depends on rvd_pkg.
module rvd_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rvd_pkg::unit_req_t             req,
	input  logic [rvd_pkg::WIDE_W-1:0]     opa,
	input  logic [rvd_pkg::WIDE_W-1:0]     opb,
	output logic [rvd_pkg::WIDE_W-1:0]     res,
	output logic                           done
);

	logic                          busy_q;
	logic                          done_q;
	logic [rvd_pkg::OP_W-1:0]      op_q;
	logic [rvd_pkg::LEN_W-1:0]     cnt_q;
	logic [rvd_pkg::WIDE_W-1:0]    a_q;
	logic [rvd_pkg::MAG_W-1:0]     b_q;
	logic [rvd_pkg::WIDE_W-1:0]    acc_q;

	logic [rvd_pkg::WIDE_W-1:0]    add_a;
	logic [rvd_pkg::WIDE_W-1:0]    add_b;
	logic                          add_sub;
	logic [rvd_pkg::WIDE_W:0]      sum;
	logic                          borrow;
	logic [rvd_pkg::MAG_W-1:0]     trial;

	assign trial = {b_q[rvd_pkg::MAG_W-2:0], acc_q[rvd_pkg::VAR_W-1]};

	always_comb begin
		add_a   = acc_q;
		add_b   = a_q;
		add_sub = 1'b1;
		unique case (op_q)
			rvd_pkg::OP_MUL: begin
				add_a   = acc_q;
				add_b   = b_q[0] ? a_q : '0;
				add_sub = 1'b0;
			end
			rvd_pkg::OP_DIV: begin
				add_a   = {{(rvd_pkg::WIDE_W-rvd_pkg::MAG_W){1'b0}}, trial};
				add_b   = a_q;
				add_sub = 1'b1;
			end
			default: begin
				add_a   = acc_q;
				add_b   = a_q;
				add_sub = 1'b1;
			end
		endcase
	end

	assign sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
		+ {{rvd_pkg::WIDE_W{1'b0}}, add_sub};
	assign borrow = sum[rvd_pkg::WIDE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= rvd_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			unique case (req.op)
				rvd_pkg::OP_MUL: begin
					a_q   <= opa;
					b_q   <= opb[rvd_pkg::MAG_W-1:0];
					acc_q <= '0;
				end
				rvd_pkg::OP_DIV: begin
					a_q   <= opb;
					b_q   <= {1'b0, opa[rvd_pkg::WIDE_W-1:rvd_pkg::VAR_W]};
					acc_q <= {{(rvd_pkg::WIDE_W-rvd_pkg::VAR_W){1'b0}},
						opa[rvd_pkg::VAR_W-1:0]};
				end
				default: begin
					a_q   <= opb;
					b_q   <= '0;
					acc_q <= opa;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				rvd_pkg::OP_MUL: begin
					acc_q <= sum[rvd_pkg::WIDE_W-1:0];
					a_q   <= {a_q[rvd_pkg::WIDE_W-2:0], 1'b0};
					b_q   <= {1'b0, b_q[rvd_pkg::MAG_W-1:1]};
				end
				rvd_pkg::OP_DIV: begin
					b_q   <= borrow ? trial : sum[rvd_pkg::MAG_W-1:0];
					acc_q <= {acc_q[rvd_pkg::WIDE_W-2:0], ~borrow};
				end
				default: begin
					acc_q <= sum[rvd_pkg::WIDE_W-1:0];
				end
			endcase
		end
	end

	assign res  = acc_q;
	assign done = done_q;

endmodule

@@ src/running_variance_decimated.sv @@
`timescale 1ns / 1ps
// Top level of the running variance block: APB register, statistics and sequencer.
// Depends on rvd_pkg and rvd_unit.

// A sample that does not trigger a report passes through the accept, square and accumulate
// states. For a sample that completes a report interval, the shared unit then runs n*n,
// n*sumsq (15 steps each), |sum|^2 (30 steps), one subtract and a 31-step restoring
// divide, one result bit per cycle.
// The input is taken again while a finished report still waits at the output.
// report_interval lives at byte address 0; a value of 0 reports on every sample.
module running_variance_decimated (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [rvd_pkg::SAMPLE_W-1:0] sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rvd_pkg::VAR_W-1:0]         variance,
	output logic [rvd_pkg::CNT_W-1:0]         samples_so_far,
	output logic                              overflow_flag
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_ACC  = 4'd2;
	localparam logic [3:0] S_NN   = 4'd3;
	localparam logic [3:0] S_WNN  = 4'd4;
	localparam logic [3:0] S_NS   = 4'd5;
	localparam logic [3:0] S_WNS  = 4'd6;
	localparam logic [3:0] S_MM   = 4'd7;
	localparam logic [3:0] S_WMM  = 4'd8;
	localparam logic [3:0] S_SUB  = 4'd9;
	localparam logic [3:0] S_WSUB = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_WDIV = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0]                          state_q;
	logic [rvd_pkg::RI_W-1:0]            ri_q;
	logic [rvd_pkg::CNT_W-1:0]           cnt_q;
	logic signed [rvd_pkg::SUM_W-1:0]    sum_q;
	logic [rvd_pkg::SSQ_W-1:0]           ssq_q;
	logic [rvd_pkg::RI_W-1:0]            ic_q;
	logic                                lim_q;
	logic signed [rvd_pkg::SAMPLE_W-1:0] x_q;
	logic [rvd_pkg::SQ_W-1:0]            sq_q;
	logic [rvd_pkg::DEN_W-1:0]           d_q;
	logic [rvd_pkg::WIDE_W-1:0]          prod_q;
	logic                                out_valid_q;
	logic [rvd_pkg::VAR_W-1:0]           variance_q;
	logic [rvd_pkg::CNT_W-1:0]           samples_q;
	logic                                flag_q;

	rvd_pkg::unit_req_t                  req;
	logic [rvd_pkg::WIDE_W-1:0]          opa;
	logic [rvd_pkg::WIDE_W-1:0]          opb;
	logic [rvd_pkg::WIDE_W-1:0]          res;
	logic                                done;

	logic                                cfg_wr;
	logic                                in_acc;
	logic [rvd_pkg::SAMPLE_W-1:0]        xmag;
	logic [2*rvd_pkg::SAMPLE_W-1:0]      xsq;
	logic [rvd_pkg::SUM_W-1:0]           sum_abs;
	logic [rvd_pkg::MAG_W-1:0]           mag;
	logic [rvd_pkg::RI_W-1:0]            lim;
	logic [rvd_pkg::RI_W:0]              ic_nx;
	logic                                full;
	logic                                out_free;

	rvd_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.res    (res),
		.done   (done)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == rvd_pkg::REG_REPORT_INTERVAL)
		? {{(32-rvd_pkg::RI_W){1'b0}}, ri_q} : 32'd0;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign xmag    = x_q[rvd_pkg::SAMPLE_W-1] ? (~x_q + 1'b1) : x_q;
	assign xsq     = xmag * xmag;
	assign sum_abs = sum_q[rvd_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign mag     = sum_abs[rvd_pkg::MAG_W-1:0];
	assign lim     = (ri_q == '0) ? {{(rvd_pkg::RI_W-1){1'b0}}, 1'b1} : ri_q;
	assign ic_nx   = {1'b0, ic_q} + 1'b1;
	assign full    = (cnt_q >= rvd_pkg::CNT_W'(rvd_pkg::MAX_SAMPLES));

	always_comb begin
		req.start = 1'b0;
		req.op    = rvd_pkg::OP_MUL;
		req.len   = rvd_pkg::LEN_CNT;
		opa       = '0;
		opb       = '0;
		unique case (state_q)
			S_NN: begin
				req.start = 1'b1;
				opa = {{(rvd_pkg::WIDE_W-rvd_pkg::CNT_W){1'b0}}, cnt_q};
				opb = {{(rvd_pkg::WIDE_W-rvd_pkg::CNT_W){1'b0}}, cnt_q};
			end
			S_NS: begin
				req.start = 1'b1;
				opa = {{(rvd_pkg::WIDE_W-rvd_pkg::SSQ_W){1'b0}}, ssq_q};
				opb = {{(rvd_pkg::WIDE_W-rvd_pkg::CNT_W){1'b0}}, cnt_q};
			end
			S_MM: begin
				req.start = 1'b1;
				req.len   = rvd_pkg::LEN_MAG;
				opa = {{(rvd_pkg::WIDE_W-rvd_pkg::MAG_W){1'b0}}, mag};
				opb = {{(rvd_pkg::WIDE_W-rvd_pkg::MAG_W){1'b0}}, mag};
			end
			S_SUB: begin
				req.start = 1'b1;
				req.op    = rvd_pkg::OP_SUB;
				req.len   = rvd_pkg::LEN_SUB;
				opa = prod_q;
				opb = res;
			end
			S_DIV: begin
				req.start = 1'b1;
				req.op    = rvd_pkg::OP_DIV;
				req.len   = rvd_pkg::LEN_DIV;
				opa = res;
				opb = {{(rvd_pkg::WIDE_W-rvd_pkg::DEN_W){1'b0}}, d_q};
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ri_q        <= rvd_pkg::RI_RESET;
			cnt_q       <= '0;
			sum_q       <= '0;
			ssq_q       <= '0;
			ic_q        <= '0;
			lim_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == rvd_pkg::REG_REPORT_INTERVAL)) begin
				ri_q <= pwdata[rvd_pkg::RI_W-1:0];
			end
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (full) begin
						lim_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + {{(rvd_pkg::SUM_W-rvd_pkg::SAMPLE_W)
							{x_q[rvd_pkg::SAMPLE_W-1]}}, x_q};
						ssq_q <= ssq_q + {{(rvd_pkg::SSQ_W-rvd_pkg::SQ_W){1'b0}}, sq_q};
					end
					if (ic_nx >= {1'b0, lim}) begin
						ic_q    <= '0;
						state_q <= S_NN;
					end else begin
						ic_q    <= ic_nx[rvd_pkg::RI_W-1:0];
						state_q <= S_IDLE;
					end
				end
				S_NN:   state_q <= S_WNN;
				S_WNN: begin
					if (done) begin
						state_q <= S_NS;
					end
				end
				S_NS:   state_q <= S_WNS;
				S_WNS: begin
					if (done) begin
						state_q <= S_MM;
					end
				end
				S_MM:   state_q <= S_WMM;
				S_WMM: begin
					if (done) begin
						state_q <= S_SUB;
					end
				end
				S_SUB:  state_q <= S_WSUB;
				S_WSUB: begin
					if (done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV:  state_q <= S_WDIV;
				S_WDIV: begin
					if (done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= rvd_pkg::SAMPLE_W'(signed'(sample[rvd_pkg::SAMPLE_BITS-1:0]));
		end
		if (state_q == S_SQ) begin
			sq_q <= xsq[rvd_pkg::SQ_W-1:0];
		end
		if ((state_q == S_WNN) && done) begin
			d_q <= res[rvd_pkg::DEN_W-1:0];
		end
		if ((state_q == S_WNS) && done) begin
			prod_q <= res;
		end
		if ((state_q == S_OUT) && out_free) begin
			variance_q <= res[rvd_pkg::VAR_W-1:0];
			samples_q  <= cnt_q;
			flag_q     <= lim_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign variance       = variance_q;
	assign samples_so_far = samples_q;
	assign overflow_flag  = flag_q;

endmodule

@@ sim/rvd_checker.sv @@
`timescale 1ns / 1ps
// Checker for running_variance_decimated: watches the APB, sample and report channels.
// Predicts every variance report and compares it field by field. Depends on rvd_pkg.
module rvd_checker
	import rvd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [VAR_W-1:0]           variance,
	input  logic [CNT_W-1:0]           samples_so_far,
	input  logic                       overflow_flag,
	output int                         fail_count,
	output int                         outstanding,
	output int                         reports_checked,
	output int                         capped_reports
);

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [VAR_W-1:0] variance;
		logic [CNT_W-1:0] count;
		logic             capped;
	} variance_report_t;

	logic [RI_W-1:0]         interval_cfg;
	logic [CNT_W-1:0]        stat_count;
	logic signed [SUM_W-1:0] stat_sum;
	logic [SSQ_W-1:0]        stat_sumsq;
	logic [RI_W-1:0]         since_report;
	logic                    store_full;
	variance_report_t        expected_reports [$];
	int                      mismatches = 0;
	int                      seen = 0;
	int                      seen_capped = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 50)
			$display("[%0t] mismatch on %s: got %0d, want %0d (report %0d)",
				$time, what, got, want, seen);
	endtask

	// Fold one sample into the statistics; return 1 when it completes a report.
	function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] raw,
			output variance_report_t rep);
		longint x;
		u64_t   mag;
		u64_t   n;
		u64_t   num;
		int     limit;
		x = longint'(raw);
		rep = '0;
		if (int'(stat_count) >= MAX_SAMPLES) begin
			store_full = 1'b1;
		end else begin
			mag = (x < 0) ? -x : x;
			stat_count = stat_count + 1'b1;
			stat_sum = stat_sum + SUM_W'(x);
			stat_sumsq = stat_sumsq + SSQ_W'(mag * mag);
		end
		limit = (interval_cfg == '0) ? 1 : int'(interval_cfg);
		since_report = since_report + 1'b1;
		if (int'(since_report) < limit)
			return 1'b0;
		since_report = '0;
		n = u64_t'(stat_count);
		if (n != 0) begin
			x = longint'(stat_sum);
			mag = (x < 0) ? -x : x;
			num = n * u64_t'(stat_sumsq) - mag * mag;
			rep.variance = VAR_W'(num / (n * n));
		end
		rep.count = stat_count;
		rep.capped = store_full;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		variance_report_t want;
		if (!arst_n) begin
			interval_cfg = RI_RESET;
			stat_count = '0;
			stat_sum = '0;
			stat_sumsq = '0;
			since_report = '0;
			store_full = 1'b0;
			expected_reports.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 &&
					paddr[2:2] == REG_REPORT_INTERVAL) begin
				interval_cfg = pwdata[RI_W-1:0];
			end
			if (in_valid && in_ready) begin
				if (fold_sample(sample, want))
					expected_reports.push_back(want);
			end
			if (out_valid && out_ready) begin
				seen++;
				if (overflow_flag === 1'b1)
					seen_capped++;
				if (expected_reports.size() == 0) begin
					report_mismatch("report with none pending", variance, 0);
				end else begin
					want = expected_reports.pop_front();
					if (variance !== want.variance)
						report_mismatch("variance", variance, want.variance);
					if (samples_so_far !== want.count)
						report_mismatch("samples_so_far", samples_so_far, want.count);
					if (overflow_flag !== want.capped)
						report_mismatch("overflow_flag", overflow_flag, want.capped);
				end
			end
		end
		fail_count <= mismatches;
		outstanding <= expected_reports.size();
		reports_checked <= seen;
		capped_reports <= seen_capped;
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for running_variance_decimated: clock, reset, APB writes, samples and
// output back-pressure; the verdict comes from rvd_checker. Depends on rvd_pkg.
module tb_top;
	import rvd_pkg::*;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 100;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic [VAR_W-1:0]    variance;
	logic [CNT_W-1:0]    samples_so_far;
	logic                overflow_flag;
	int                  fail_count;
	int                  outstanding;
	int                  reports_checked;
	int                  capped_reports;

	bit hold_output = 1'b0;
	int fed = 0;

	logic [SAMPLE_W-1:0] corner_samples [10] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
		16'h0001, 16'h5555, 16'hAAAA, 16'h4000, 16'hC000, 16'h7FFF};
	logic [RI_W-1:0] phase_intervals [8] = '{8'd1, 8'd7, 8'd255, 8'd2, 8'd0, 8'd10, 8'd3,
		8'd100};

	running_variance_decimated u_dut (.*);

	rvd_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : sink
		int roll;
		int len;
		out_ready <= 1'b0;
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 40);
				end else if (roll < 93) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 4);
				end else begin
					out_ready <= 1'b0;
					len = $urandom_range(20, 80);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	function automatic int next_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 16'h7FFF;
		if (roll == 1)
			return 16'h8000;
		if (roll == 2)
			return SAMPLE_W'($urandom_range(0, 31)) - 16'd16;
		return SAMPLE_W'($urandom);
	endfunction

	task automatic push_sample(input logic [SAMPLE_W-1:0] value, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fed++;
	endtask

	// Drop valid, wait out every pending report, then let the block go idle.
	task automatic drain_and_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input logic [RI_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : stimulus
		int p;
		int k;
		logic [RI_W-1:0] ri;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset interval of ten: one report over the corner samples
		foreach (corner_samples[i])
			push_sample(corner_samples[i], next_gap());
		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd0);
		push_sample(16'h8000, 0);
		push_sample(16'h7FFF, next_gap());
		push_sample(16'h0000, 0);
		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd1);
		push_sample(16'hFFFF, 0);
		push_sample(16'h0001, 0);
		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd50);
		for (k = 0; k < 8; k++)
			push_sample(pick_sample(), next_gap());
		// lower the interval below the running count: next sample reports
		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd4);
		push_sample(pick_sample(), 0);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_and_wait();
			ri = (p < 8) ? phase_intervals[p] : RI_W'($urandom_range(1, 255));
			write_reg(REG_REPORT_INTERVAL, ri);
			if (p == 0)
				hold_output = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 5 && k == PHASE_ITEMS / 2)
					drain_and_wait();
				push_sample(pick_sample(), (p == 2 || p == 7) ? 0 : next_gap());
			end
		end

		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd3);
		for (k = 0; k < 30; k++)
			push_sample(pick_sample(), next_gap());
		drain_and_wait();
		write_reg(REG_REPORT_INTERVAL, 8'd1);
		for (k = 0; k < 10; k++)
			push_sample(pick_sample(), next_gap());
		drain_and_wait();

		$display("Drove %0d samples: %0d variance reports checked, %0d flagged.",
			fed, reports_checked, capped_reports);
		$display("Intervals 0, 1, 255, random and lowered mid-count; %0d-cycle output hold, drain pause.",
			HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/rvd_pkg.sv
src/rvd_unit.sv
src/running_variance_decimated.sv
sim/rvd_checker.sv
sim/tb_top.sv
